### rtl/bga_pkg.sv
// Shared types and constants for the baud generator allocator.
package bga_pkg;

    localparam int CLK_W   = 30;
    localparam int BAUD_W  = 20;
    localparam int GIDX_W  = 2;
    localparam int DIV_W   = 12;
    localparam int NUM_W   = CLK_W - 4 + 1;
    localparam int QUOT_W  = NUM_W;
    localparam int REM_W   = BAUD_W + 1;
    localparam int STEP_W  = $clog2(QUOT_W);

    localparam logic [CLK_W-1:0]  CLK_RESET = CLK_W'(25000000);
    localparam logic [QUOT_W:0]   DIV_MAX   = (QUOT_W + 1)'(4096);
    localparam logic [QUOT_W:0]   PRE_ROUND = (QUOT_W + 1)'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_res;

endpackage

### rtl/bga_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module bga_div
    import bga_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_dividend,
    input  logic [BAUD_W-1:0] i_divisor,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quotient
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic [BAUD_W-1:0] r_dvsr;

    logic [REM_W-1:0]  n_shift;
    logic              n_ge;

    always_comb begin
        n_shift = {r_rem[REM_W-2:0], r_quot[QUOT_W-1]};
        n_ge    = (n_shift >= {1'b0, r_dvsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_ge ? (n_shift - {1'b0, r_dvsr}) : n_shift;
            r_quot <= {r_quot[QUOT_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

### rtl/bga_table.sv
// Generator rate table with a sequential search for a match or a free entry.
module bga_table
    import bga_pkg::*;
#(
    parameter int NUM_GENERATORS = 4,
    parameter int IDX_W          = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BAUD_W-1:0] i_baud,
    output t_scan_res         o_res,
    output logic [IDX_W-1:0]  o_idx
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_GENERATORS - 1);

    logic [BAUD_W-1:0]         r_rate [NUM_GENERATORS];
    logic [NUM_GENERATORS-1:0] r_in_use;

    logic             r_busy;
    logic [IDX_W-1:0] r_cnt;
    logic             r_match_f;
    logic [IDX_W-1:0] r_match_idx;
    logic             r_free_f;
    logic [IDX_W-1:0] r_free_idx;
    t_scan_res        r_res;
    logic [IDX_W-1:0] r_idx;

    logic             n_hit;
    logic             n_free;
    logic             n_m_f;
    logic [IDX_W-1:0] n_m_idx;
    logic             n_f_f;
    logic [IDX_W-1:0] n_f_idx;
    logic             n_found;
    logic [IDX_W-1:0] n_pick;

    always_comb begin
        n_hit   = r_in_use[r_cnt] && (r_rate[r_cnt] == i_baud);
        n_free  = !r_in_use[r_cnt];
        n_m_f   = r_match_f | n_hit;
        n_m_idx = r_match_f ? r_match_idx : r_cnt;
        n_f_f   = r_free_f | n_free;
        n_f_idx = r_free_f ? r_free_idx : r_cnt;
        n_found = n_m_f | n_f_f;
        n_pick  = n_m_f ? n_m_idx : n_f_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_match_f <= 1'b0;
            r_free_f  <= 1'b0;
            r_in_use  <= '0;
            r_res     <= '0;
        end else begin
            r_res.done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_match_f <= 1'b0;
                r_free_f  <= 1'b0;
            end else if (r_busy) begin
                r_match_f <= n_m_f;
                r_free_f  <= n_f_f;
                r_cnt     <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy      <= 1'b0;
                    r_res.done  <= 1'b1;
                    r_res.found <= n_found;
                    if (n_found) begin
                        r_in_use[n_pick] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_match_idx <= n_m_idx;
            r_free_idx  <= n_f_idx;
            if (r_cnt == LAST) begin
                r_idx <= n_pick;
                if (n_found) begin
                    r_rate[n_pick] <= i_baud;
                end
            end
        end
    end

    assign o_res = r_res;
    assign o_idx = r_idx;

endmodule

### rtl/baud_generator_allocator_core.sv
// Top level of the baud generator allocator: sequencer, clock register, result register.
//
// Usage:
// - Request channel: i_in_valid / o_in_ready carry i_baud_rate. One request is
//   taken at a time; o_in_ready is high only while the block is idle.
// - Response channel: o_out_valid / i_out_ready carry o_granted,
//   o_generator_index, o_divisor_minus_one and o_prescale_by_16.
// - Path from request to response valid: when a generator is granted, the
//   table is searched one entry per cycle, the divider is started, the
//   bit-serial divider runs and the result is registered; when all are busy
//   only the search runs, and a zero rate goes straight to the response.
// - Requests do not overlap: a new request is taken only after the previous
//   response has been accepted; the divider is the longest step.
// - Configuration: i_cfg_we writes i_cfg_wdata into the system clock register
//   at once; write only while idle.
// - Reset clears the used flags and loads the clock register with 25 MHz.
// - A stalled receiver holds the response; no new request is taken until the
//   response is accepted.
module baud_generator_allocator_core
    import bga_pkg::*;
#(
    parameter int NUM_GENERATORS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CLK_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BAUD_W-1:0] i_baud_rate,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_granted,
    output logic [GIDX_W-1:0] o_generator_index,
    output logic [DIV_W-1:0]  o_divisor_minus_one,
    output logic              o_prescale_by_16
);

    localparam int IDX_W = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;

    t_state            r_state;
    t_state            n_state;
    logic [CLK_W-1:0]  r_clk_hz;
    logic [BAUD_W-1:0] r_baud;
    logic              r_granted;
    logic [GIDX_W-1:0] r_gen_idx;
    logic [DIV_W-1:0]  r_div_m1;
    logic              r_pre;

    logic              in_acc;
    logic              scan_start;
    logic              div_start;
    logic              out_valid;
    t_scan_res         scan_res;
    logic [IDX_W-1:0]  scan_idx;
    logic              div_done;
    logic [QUOT_W-1:0] quot;
    logic [NUM_W-1:0]  dividend;

    logic                     pre;
    logic [QUOT_W:0]          q_ext;
    logic [QUOT_W:0]          q_round;
    logic [QUOT_W:0]          q_sel;
    logic [QUOT_W:0]          d_sat;
    logic [QUOT_W:0]          d_m1;
    logic [GIDX_W+IDX_W-1:0]  idx_ext;

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_baud_rate == '0) ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_res.done) begin
                    n_state = scan_res.found ? ST_DIV : ST_RESP;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        out_valid  = 1'b0;
        scan_start = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                scan_start = i_in_valid && (i_baud_rate != '0);
            end
            ST_SCAN: div_start = scan_res.done && scan_res.found;
            ST_DIV:  ;
            ST_RESP: out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_clk_hz <= CLK_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_wdata;
            end
        end
    end

    assign dividend = NUM_W'(r_clk_hz[CLK_W-1:4]) + NUM_W'(r_baud[BAUD_W-1:1]);

    always_comb begin
        q_ext   = {1'b0, quot};
        pre     = (q_ext > DIV_MAX);
        q_round = (q_ext + PRE_ROUND) >> 4;
        q_sel   = pre ? q_round : q_ext;
        if (q_sel == '0) begin
            d_sat = (QUOT_W + 1)'(1);
        end else if (q_sel > DIV_MAX) begin
            d_sat = DIV_MAX;
        end else begin
            d_sat = q_sel;
        end
        d_m1    = d_sat - 1'b1;
        idx_ext = {{GIDX_W{1'b0}}, scan_idx};
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_baud    <= i_baud_rate;
                    r_granted <= 1'b0;
                    r_gen_idx <= '0;
                    r_div_m1  <= '0;
                    r_pre     <= 1'b0;
                end
            end
            ST_SCAN: begin
                if (scan_res.done && scan_res.found) begin
                    r_gen_idx <= idx_ext[GIDX_W-1:0];
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    r_granted <= 1'b1;
                    r_div_m1  <= d_m1[DIV_W-1:0];
                    r_pre     <= pre;
                end
            end
            ST_RESP: ;
            default: ;
        endcase
    end

    bga_table #(
        .NUM_GENERATORS (NUM_GENERATORS),
        .IDX_W          (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_baud  (r_state == ST_IDLE ? i_baud_rate : r_baud),
        .o_res   (scan_res),
        .o_idx   (scan_idx)
    );

    bga_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_baud),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    assign o_out_valid         = out_valid;
    assign o_granted           = r_granted;
    assign o_generator_index   = r_gen_idx;
    assign o_divisor_minus_one = r_div_m1;
    assign o_prescale_by_16    = r_pre;

endmodule
